@@ design/frame_luma_mean_unit_defines.svh @@
// Assertion macros for the frame luma mean unit.
`ifndef FRAME_LUMA_MEAN_UNIT_DEFINES_SVH
`define FRAME_LUMA_MEAN_UNIT_DEFINES_SVH

// Same-cycle implication, off during reset.
`define FLM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frame_luma_mean_unit: assertion failed");

// Next-cycle implication, off during reset.
`define FLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frame_luma_mean_unit: assertion failed");

`endif

@@ design/flm_pkg.sv @@
`default_nettype none
package flm_pkg;

  localparam int SAMPLE_STRIDE = 8;
  localparam int MAX_PIXELS    = 65536;
  localparam int SAMPLE_CAP    = (MAX_PIXELS + SAMPLE_STRIDE - 1) / SAMPLE_STRIDE;

  localparam int PIXEL_W = 16;
  localparam int MEAN_W  = 9;
  localparam int SUM_W   = 24;
  localparam int COUNT_W = 17;
  localparam int LUMA_W  = 8;
  localparam int PHASE_W = (SAMPLE_STRIDE > 1) ? $clog2(SAMPLE_STRIDE) : 1;
  localparam int STEP_W  = $clog2(LUMA_W);

  localparam int S_DATA_W = 16;
  localparam int M_DATA_W = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [APB_AW-1:0] ADDR_SOURCE_USABLE = 3'h0;
  localparam logic [MEAN_W-1:0] MEAN_UNUSABLE      = '1;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic take;       // pixel transfer this cycle
    logic take_last;  // that pixel closes the frame
    logic div_step;   // one quotient bit
    logic finish;     // load result, clear frame
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

  // Approximate Rec.601 luma of an RGB565 pixel, channels widened to 8 bits.
  function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] px);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] acc;
    r8  = {px[15:11], 3'b000};
    g8  = {px[10:5], 2'b00};
    b8  = {px[4:0], 3'b000};
    // products and sum stay below 2^16
    acc = 16'(r8) * 16'd77 + 16'(g8) * 16'd150 + 16'(b8) * 16'd29;
    return acc[15:8];
  endfunction

endpackage
`default_nettype wire

@@ design/flm_regs.sv @@
`default_nettype none
module flm_regs (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [flm_pkg::APB_AW-1:0]   paddr,
  input  wire logic [flm_pkg::APB_DW-1:0]   pwdata,
  output logic      [flm_pkg::APB_DW-1:0]   prdata,
  output logic                              pready,
  output logic                              source_usable
);

  logic hit;

  assign pready = 1'b1;
  assign hit    = (paddr == flm_pkg::ADDR_SOURCE_USABLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_usable <= 1'b0;
    end else if (psel && penable && pwrite && pready && hit) begin
      source_usable <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata[0] = source_usable;
    end
  end

endmodule
`default_nettype wire

@@ design/flm_ctrl.sv @@
`default_nettype none
module flm_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tlast,
  output logic                  s_tready,
  input  wire flm_pkg::status_t status,
  output flm_pkg::cmd_t         cmd
);

  flm_pkg::state_t state;
  flm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flm_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    unique case (state)
      flm_pkg::ST_ACCEPT: begin
        s_tready      = 1'b1;
        cmd.take      = s_tvalid;
        cmd.take_last = s_tvalid && s_tlast;
        if (s_tvalid && s_tlast) begin
          state_next = flm_pkg::ST_DIVIDE;
        end
      end
      flm_pkg::ST_DIVIDE: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = flm_pkg::ST_FINISH;
        end
      end
      flm_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = flm_pkg::ST_ACCEPT;
        end
      end
      default: begin
        state_next = flm_pkg::ST_ACCEPT;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/flm_dpath.sv @@
`default_nettype none
module flm_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [flm_pkg::PIXEL_W-1:0]   pixel,
  input  wire logic                          source_usable,
  input  wire flm_pkg::cmd_t                 cmd,
  output flm_pkg::status_t                   status,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [flm_pkg::MEAN_W-1:0]    brightness_mean
);

  logic [flm_pkg::PHASE_W-1:0] phase;
  logic [flm_pkg::SUM_W-1:0]   luma_sum;
  logic [flm_pkg::COUNT_W-1:0] sample_count;
  logic [flm_pkg::STEP_W-1:0]  step;
  logic [flm_pkg::LUMA_W-1:0]  quot;

  logic                        sample;
  logic [flm_pkg::PHASE_W-1:0] phase_next;
  logic [flm_pkg::SUM_W-1:0]   shifted;
  logic                        fits;

  assign sample = (phase == '0) &&
                  (sample_count < flm_pkg::COUNT_W'(flm_pkg::SAMPLE_CAP));
  assign phase_next = (phase == flm_pkg::PHASE_W'(flm_pkg::SAMPLE_STRIDE - 1)) ?
                      '0 : phase + 1'b1;

  // Restoring division; the mean never exceeds 255, so eight steps suffice.
  assign shifted = flm_pkg::SUM_W'(sample_count) << step;
  assign fits    = (luma_sum >= shifted);

  assign status.div_last = (step == '0);
  assign status.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= '0;
      luma_sum     <= '0;
      sample_count <= '0;
      step         <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cmd.take) begin
        if (sample) begin
          luma_sum     <= flm_pkg::SUM_W'(luma_sum +
                          flm_pkg::SUM_W'(flm_pkg::luma_of(pixel)));
          sample_count <= sample_count + 1'b1;
        end
        phase <= cmd.take_last ? '0 : phase_next;
        if (cmd.take_last) begin
          step <= flm_pkg::STEP_W'(flm_pkg::LUMA_W - 1);
        end
      end
      if (cmd.div_step) begin
        if (fits) begin
          luma_sum <= luma_sum - shifted;
        end
        step <= step - 1'b1;
      end
      if (cmd.finish) begin
        luma_sum     <= '0;
        sample_count <= '0;
        m_tvalid     <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      quot <= {quot[flm_pkg::LUMA_W-2:0], fits};
    end
    if (cmd.finish) begin
      brightness_mean <= source_usable ? {1'b0, quot} : flm_pkg::MEAN_UNUSABLE;
    end
  end

endmodule
`default_nettype wire

@@ design/frame_luma_mean_unit.sv @@
// Channel   Dir  Bits  Contents
// s_axis    in   16+1  tdata: pixel (RGB565); tlast: last pixel of frame
// m_axis    out  16    tdata: brightness_mean (9-bit unsigned, zero padded)
// apb       in   32    reg 0 at 0x0: source_usable (bit 0)
//
// Pixels transfer one per cycle while s_tready is high; every eighth pixel of
// a frame, from the first and up to 8192 samples, is summed as it transfers.
// After the last pixel, s_tready drops: eight steps of the restoring divider,
// then the output load, which waits while an untaken result is still held.
// Synchronous active-high reset clears the sum, count, phase, register and
// output valid. Pixels keep flowing while a result waits at the output.
`default_nettype none
module frame_luma_mean_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [flm_pkg::S_DATA_W-1:0] s_tdata,  // [15:0] pixel
  input  wire logic                        s_tlast,   // last_pixel
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [flm_pkg::M_DATA_W-1:0] m_tdata,  // [8:0] brightness_mean
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [flm_pkg::APB_AW-1:0]  paddr,
  input  wire logic [flm_pkg::APB_DW-1:0]  pwdata,
  output logic      [flm_pkg::APB_DW-1:0]  prdata,
  output logic                             pready
);

  logic                          source_usable;
  flm_pkg::cmd_t                 cmd;
  flm_pkg::status_t              status;
  logic [flm_pkg::MEAN_W-1:0]    brightness_mean;

  flm_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .source_usable (source_usable)
  );

  flm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  flm_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .pixel           (s_tdata[flm_pkg::PIXEL_W-1:0]),
    .source_usable   (source_usable),
    .cmd             (cmd),
    .status          (status),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .brightness_mean (brightness_mean)
  );

  assign m_tdata = flm_pkg::M_DATA_W'(brightness_mean);

endmodule
`default_nettype wire

@@ design/flm_checker.sv @@
`default_nettype none
`include "frame_luma_mean_unit_defines.svh"
module flm_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  input  wire logic                         s_tlast,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic [flm_pkg::M_DATA_W-1:0] m_tdata
);

  // A stalled result holds.
  `FLM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The divider runs after the frame's last pixel, so input is paused.
  `FLM_ASSERT_NEXT(a_busy_after_last, clk, rst, s_tvalid && s_tready && s_tlast, !s_tready)

  // Result is a mean in 0..255 or the unusable code, zero padded.
  `FLM_ASSERT_SAME(a_out_range, clk, rst, m_tvalid, (m_tdata[15:9] == 7'd0) && ((m_tdata[8] == 1'b0) || (m_tdata[8:0] == 9'h1FF)))

  // A new result only appears out of a paused input.
  `FLM_ASSERT_SAME(a_result_after_pause, clk, rst, $rose(m_tvalid), !$past(s_tready))

endmodule

bind frame_luma_mean_unit flm_checker u_flm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

@@ test/frame_luma_mean_unit_tb.sv @@
`default_nettype none
module frame_luma_mean_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_OFF_CYCLES = 400;  // long receiver hold-off
  localparam int SETTLE_CYCLES   = 16;   // divider plus output load, with margin
  localparam int STALL_LIMIT     = 4000; // cycles without any transfer
  localparam logic [flm_pkg::APB_AW-1:0] ADDR_UNMAPPED = 3'h4;

  typedef struct packed {
    logic [flm_pkg::PIXEL_W-1:0] px;
    logic                        last;
  } pixel_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                         s_tvalid = 1'b0;
  logic                         s_tready;
  logic [flm_pkg::S_DATA_W-1:0] s_tdata = '0;  // [15:0] pixel
  logic                         s_tlast = 1'b0;  // last_pixel
  logic                         m_tvalid;
  logic                         m_tready = 1'b0;
  logic [flm_pkg::M_DATA_W-1:0] m_tdata;  // [8:0] brightness_mean, [15:9] zero
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [flm_pkg::APB_AW-1:0]   paddr = '0;
  logic [flm_pkg::APB_DW-1:0]   pwdata = '0;
  logic [flm_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  frame_luma_mean_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pixel_item_t                  pixel_q[$];
  logic [flm_pkg::MEAN_W-1:0]   mean_expect_q[$];

  // shadow of the block's frame state
  logic                         usable_shadow = 1'b0;
  logic [flm_pkg::PHASE_W-1:0]  frame_phase = '0;
  logic [flm_pkg::SUM_W-1:0]    frame_sum = '0;
  logic [flm_pkg::COUNT_W-1:0]  frame_samples = '0;

  int  err_count = 0;
  int  pixels_sent = 0;
  int  means_checked = 0;
  bit  tx_idle_on = 1'b0;
  bit  rx_idle_on = 1'b0;
  int  hold_off_req = 0;
  int  hold_off_seen = 0;

  // handshakes latched mid-cycle; inputs and outputs are stable from here to the edge
  logic                         in_xfer = 1'b0;
  logic                         out_xfer = 1'b0;
  logic [flm_pkg::M_DATA_W-1:0] out_word = '0;

  always @(negedge clk) begin
    in_xfer  <= s_tvalid & s_tready;
    out_xfer <= m_tvalid & m_tready;
    out_word <= m_tdata;
  end

  task automatic report(input string what, input int got, input int want);
    err_count++;
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
  endtask

  function automatic int draw_gap(input bit on);
    int r;
    r = $urandom_range(0, 99);
    if (!on || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [flm_pkg::LUMA_W-1:0] rec601_luma(
      input logic [flm_pkg::PIXEL_W-1:0] px);
    int unsigned red, grn, blu;
    red = 32'(px[15:11]) * 8;
    grn = 32'(px[10:5]) * 4;
    blu = 32'(px[4:0]) * 8;
    return flm_pkg::LUMA_W'((red * 77 + grn * 150 + blu * 29) / 256);
  endfunction

  task automatic absorb_pixel(input logic [flm_pkg::PIXEL_W-1:0] px, input logic last);
    int unsigned quot;
    if (frame_phase == '0 && frame_samples < flm_pkg::SAMPLE_CAP) begin
      frame_sum     = frame_sum + rec601_luma(px);
      frame_samples = frame_samples + 1'b1;
    end
    frame_phase = (frame_phase == flm_pkg::PHASE_W'(flm_pkg::SAMPLE_STRIDE - 1)) ?
                  '0 : frame_phase + 1'b1;
    if (last) begin
      if (!usable_shadow) begin
        mean_expect_q.push_back(flm_pkg::MEAN_UNUSABLE);
      end else begin
        quot = (frame_samples != 0) ? frame_sum / frame_samples : 0;
        if (quot > 255) quot = 255;
        mean_expect_q.push_back(flm_pkg::MEAN_W'(quot));
      end
      frame_phase   = '0;
      frame_sum     = '0;
      frame_samples = '0;
    end
  endtask

  task automatic check_mean(input logic [flm_pkg::M_DATA_W-1:0] got);
    logic [flm_pkg::MEAN_W-1:0] want;
    if (mean_expect_q.size() == 0) begin
      report("result with no frame pending", got, 0);
      return;
    end
    want = mean_expect_q.pop_front();
    means_checked++;
    if (got[flm_pkg::MEAN_W-1:0] !== want)
      report("brightness_mean", got[flm_pkg::MEAN_W-1:0], want);
    if (got[flm_pkg::M_DATA_W-1:flm_pkg::MEAN_W] !== '0)
      report("tdata padding", got[flm_pkg::M_DATA_W-1:flm_pkg::MEAN_W], 0);
  endtask

  // pixel sender
  int tx_gap = 0;
  always @(posedge clk) begin : pixel_sender
    pixel_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap   <= 0;
    end else begin
      if (in_xfer) begin
        absorb_pixel(s_tdata[flm_pkg::PIXEL_W-1:0], s_tlast);
        pixels_sent++;
      end
      if (s_tvalid && !in_xfer) begin
        // hold the offered pixel until it transfers
      end else if (tx_gap != 0) begin
        s_tvalid <= 1'b0;
        tx_gap   <= tx_gap - 1;
      end else if (pixel_q.size() != 0) begin
        nxt = pixel_q.pop_front();
        s_tdata  <= nxt.px;
        s_tlast  <= nxt.last;
        s_tvalid <= 1'b1;
        tx_gap   <= draw_gap(tx_idle_on);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver
  int rx_gap = 0;
  int rx_hold = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_gap   <= 0;
    end else begin
      if (out_xfer) check_mean(out_word);
      if (hold_off_req != hold_off_seen) begin
        hold_off_seen <= hold_off_req;
        rx_hold       <= HOLD_OFF_CYCLES;
        m_tready      <= 1'b0;
      end else if (rx_hold != 0) begin
        rx_hold  <= rx_hold - 1;
        m_tready <= 1'b0;
      end else if (rx_gap != 0) begin
        rx_gap   <= rx_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        rx_gap   <= draw_gap(rx_idle_on);
      end
    end
  end

  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || in_xfer || out_xfer) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[%0t] no transfer for %0d cycles, %0d results pending",
               $realtime, quiet_cycles, mean_expect_q.size());
      $display("frame_luma_mean_unit_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic apb_write(input logic [flm_pkg::APB_AW-1:0] addr,
                           input logic [flm_pkg::APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == flm_pkg::ADDR_SOURCE_USABLE) usable_shadow = data[0];
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (pixel_q.size() != 0 || s_tvalid || mean_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic push_pixel(input logic [flm_pkg::PIXEL_W-1:0] px, input logic last);
    pixel_item_t it;
    it.px   = px;
    it.last = last;
    pixel_q.push_back(it);
  endtask

  task automatic push_frame(input int len, input bit extremes);
    logic [flm_pkg::PIXEL_W-1:0] px;
    for (int i = 0; i < len; i++) begin
      px = flm_pkg::PIXEL_W'($urandom_range(0, 65535));
      if (extremes) begin
        case ($urandom_range(0, 5))
          0: px = 16'h0000;
          1: px = 16'hFFFF;
          2: px = 16'hF800;
          3: px = 16'h07E0;
          4: px = 16'h001F;
          default: ;
        endcase
      end
      push_pixel(px, i == len - 1);
    end
  endtask

  function automatic int draw_frame_len(input bit short_only);
    int r;
    if (short_only) return $urandom_range(1, 4);
    r = $urandom_range(0, 99);
    if (r < 40) return $urandom_range(1, 8);
    if (r < 80) return $urandom_range(9, 40);
    if (r < 95) return $urandom_range(41, 120);
    return $urandom_range(121, 400);
  endfunction

  task automatic run_phase(input bit usable, input bit tx_on, input bit rx_on,
                           input bit squeeze, input int n_items);
    int added;
    int len;
    added = 0;
    apb_write(flm_pkg::ADDR_SOURCE_USABLE, flm_pkg::APB_DW'(usable));
    @(negedge clk);
    tx_idle_on = tx_on;
    rx_idle_on = rx_on;
    // receiver holds off while short frames pile up behind the output register
    if (squeeze) hold_off_req = hold_off_req + 1;
    while (added < n_items) begin
      len = draw_frame_len(squeeze);
      push_frame(len, $urandom_range(0, 3) == 0);
      added += len;
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset leaves the source unusable
    push_pixel(16'hFFFF, 1'b1);
    push_pixel(16'h1234, 1'b0);
    push_pixel(16'h0000, 1'b0);
    push_pixel(16'hFFFF, 1'b1);
    wait_drained();
    apb_write(flm_pkg::ADDR_SOURCE_USABLE, 32'h1);
    @(negedge clk);
    push_pixel(16'h0000, 1'b1);
    push_pixel(16'hFFFF, 1'b1);
    push_pixel(16'hF800, 1'b1);
    push_pixel(16'h07E0, 1'b1);
    push_pixel(16'h001F, 1'b1);
    // nine pixels: only the first and the ninth are sampled
    for (int i = 0; i < 9; i++) push_pixel((i == 0 || i == 8) ? 16'hFFFF : 16'h0000, i == 8);
    // eight pixels: only the first is sampled
    for (int i = 0; i < 8; i++) push_pixel((i == 0) ? 16'h0000 : 16'hFFFF, i == 7);
    wait_drained();
    // write outside the register map must not touch source_usable
    apb_write(ADDR_UNMAPPED, 32'h0);
    @(negedge clk);
    push_pixel(16'hFFFF, 1'b1);
    wait_drained();

    run_phase(1'b1, 1'b1, 1'b1, 1'b0, 300);
    run_phase(1'b0, 1'b0, 1'b0, 1'b0, 250);
    run_phase(1'b1, 1'b0, 1'b0, 1'b1, 250);
    run_phase(1'b1, 1'b1, 1'b0, 1'b0, 300);
    run_phase(1'b0, 1'b0, 1'b1, 1'b0, 150);
    run_phase(1'b1, 1'b0, 1'b1, 1'b0, 150);

    repeat (40) @(negedge clk);
    if (mean_expect_q.size() != 0) report("frames never answered", mean_expect_q.size(), 0);
    $display("run: %0d pixels, %0d frame means checked, %0d mismatches",
             pixels_sent, means_checked, err_count);
    $display("run: usable and unusable source, stride edges, unmapped write, backpressure");
    if (err_count == 0) begin
      $display("frame_luma_mean_unit_tb: clean");
    end else begin
      $display("frame_luma_mean_unit_tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
